// File: design/mctok_pkg.sv
// ----------------------------------------------------------------------------
// mctok_pkg
// Shared types and constants of the microcode source tokenizer: token kinds,
// error codes, default counter widths and the keyword spelling table.
// ----------------------------------------------------------------------------
package mctok_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int NUM_BITS        = 31;
	localparam int KIND_BITS       = 5;
	localparam int ERR_BITS        = 2;
	localparam int KW_COUNT        = 5;

	localparam logic [KIND_BITS-1:0] TK_EOF     = 5'd0;
	localparam logic [KIND_BITS-1:0] TK_LPAREN  = 5'd1;
	localparam logic [KIND_BITS-1:0] TK_RPAREN  = 5'd2;
	localparam logic [KIND_BITS-1:0] TK_LBRACE  = 5'd3;
	localparam logic [KIND_BITS-1:0] TK_RBRACE  = 5'd4;
	localparam logic [KIND_BITS-1:0] TK_SEMI    = 5'd5;
	localparam logic [KIND_BITS-1:0] TK_COLON   = 5'd6;
	localparam logic [KIND_BITS-1:0] TK_EQUALS  = 5'd7;
	localparam logic [KIND_BITS-1:0] TK_COMMA   = 5'd8;
	localparam logic [KIND_BITS-1:0] TK_STRING  = 5'd9;
	localparam logic [KIND_BITS-1:0] TK_NUMBER  = 5'd10;
	localparam logic [KIND_BITS-1:0] TK_IDENT   = 5'd11;
	localparam logic [KIND_BITS-1:0] TK_HEADER  = 5'd12;
	localparam logic [KIND_BITS-1:0] TK_ERROR   = 5'd17;

	localparam logic [ERR_BITS-1:0] ERR_NONE       = 2'd0;
	localparam logic [ERR_BITS-1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [ERR_BITS-1:0] ERR_TOO_LARGE  = 2'd2;

	// keywords, in token kind order starting at TK_HEADER
	localparam logic [63:0] KW_WORD [KW_COUNT] = '{"header", "include", "input", "opcode", "type"};
	localparam logic [2:0]  KW_LEN  [KW_COUNT] = '{3'd6, 3'd7, 3'd5, 3'd6, 3'd4};

	typedef struct packed {
		logic first;
		logic second;
	} mctok_push_t;

	// character pos of keyword k; caller guarantees pos < KW_LEN[k]
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
		logic [2:0]  sh;
		logic [63:0] w;
		w  = KW_WORD[k];
		sh = KW_LEN[k] - 3'd1 - pos;
		return w[{sh, 3'b000} +: 8];
	endfunction

endpackage

// File: design/mctok_if.sv
// ----------------------------------------------------------------------------
// mctok interfaces
// Valid/ready channels of the tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface mctok_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_text;

	modport source(output valid, output char_byte, output end_of_text, input ready);
	modport sink(input valid, input char_byte, input end_of_text, output ready);
endinterface

interface mctok_tok_if #(
	parameter int OFFSET_BITS = mctok_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = mctok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = mctok_pkg::COLUMN_BITS_DEF
);
	import mctok_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [KIND_BITS-1:0]   token_kind;
	logic [ERR_BITS-1:0]    error_code;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [OFFSET_BITS-1:0] token_length;
	logic [LINE_BITS-1:0]   line_number;
	logic [COLUMN_BITS-1:0] column_number;
	logic [NUM_BITS-1:0]    number_value;
	logic                   last_of_run;

	modport source(output valid, output token_kind, output error_code, output start_offset,
		output token_length, output line_number, output column_number, output number_value,
		output last_of_run, input ready);
	modport sink(input valid, input token_kind, input error_code, input start_offset,
		input token_length, input line_number, input column_number, input number_value,
		input last_of_run, output ready);
endinterface

// File: design/microcode_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// microcode_source_tokenizer_top
// Streaming tokenizer for microcode source text, one byte per transfer.
// ----------------------------------------------------------------------------
// Accepts one source byte (or end-of-text mark) per cycle while the queue has
// room for two tokens, and emits tokens with offset, length, line, column and
// numeric value. A byte is registered, scanned by the combinational scan step
// and its tokens are written into a four-entry queue once it has room; the
// queue's head drives the output. Most bytes yield zero or one token, so the
// sustained rate is one byte per cycle while the output keeps up. A byte that
// ends a number or identifier and is itself a token, or an end-of-text with a
// pending token, yields two tokens; the output drains at most one token per
// cycle, so a long run of such bytes is limited by the queue's single read
// port. Input ready depends only on registered state.
// ----------------------------------------------------------------------------
module microcode_source_tokenizer_top #(
	parameter int OFFSET_BITS = mctok_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = mctok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = mctok_pkg::COLUMN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mctok_char_if.sink   chars,
	mctok_tok_if.source  tokens
);
	import mctok_pkg::*;

	localparam int RES_W = KIND_BITS + ERR_BITS + 2 * OFFSET_BITS + LINE_BITS + COLUMN_BITS
		+ NUM_BITS + 1;

	logic         v_s1;
	logic [7:0]   char_s1;
	logic         eot_s1;
	logic         take;
	logic         space2;
	mctok_push_t  push;
	logic [RES_W-1:0] res0, res1, q_data;

	assign take        = v_s1 && space2;
	assign chars.ready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_byte;
			eot_s1  <= chars.end_of_text;
		end
	end

	mctok_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.RES_W      (RES_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.char_byte  (char_s1),
		.end_of_text(eot_s1),
		.push       (push),
		.res0       (res0),
		.res1       (res1)
	);

	mctok_outq #(
		.W(RES_W)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata0   (res0),
		.wdata1   (res1),
		.space2   (space2),
		.out_valid(tokens.valid),
		.out_ready(tokens.ready),
		.out_data (q_data)
	);

	assign {tokens.token_kind, tokens.error_code, tokens.start_offset, tokens.token_length,
		tokens.line_number, tokens.column_number, tokens.number_value,
		tokens.last_of_run} = q_data;

endmodule

// File: design/mctok_core.sv
// ----------------------------------------------------------------------------
// mctok_core
// Scanner state and the combinational scan step: takes one registered byte,
// updates the scan state and produces up to two packed tokens.
// ----------------------------------------------------------------------------
module mctok_core #(
	parameter int OFFSET_BITS = mctok_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = mctok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = mctok_pkg::COLUMN_BITS_DEF,
	parameter int RES_W       = mctok_pkg::KIND_BITS + mctok_pkg::ERR_BITS + 2 * OFFSET_BITS
		+ LINE_BITS + COLUMN_BITS + mctok_pkg::NUM_BITS + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [7:0]                char_byte,
	input  logic                      end_of_text,
	output mctok_pkg::mctok_push_t    push,
	output logic [RES_W-1:0]          res0,
	output logic [RES_W-1:0]          res1
);
	import mctok_pkg::*;

	localparam int TOK_W = RES_W - 1;

	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_LBR  = 8'h7B;
	localparam logic [7:0] CH_RBR  = 8'h7D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_COL  = 8'h3A;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_CMA  = 8'h2C;

	typedef enum logic [2:0] {
		M_IDLE,
		M_COMMENT,
		M_DEC,
		M_HEX,
		M_IDENT,
		M_STRING
	} mode_t;

	mode_t                  mode_q, mode_n;
	logic                   qk_q, qk_n;
	logic [OFFSET_BITS-1:0] tso_q, tso_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [COLUMN_BITS-1:0] col_q, col_n;
	logic [NUM_BITS-1:0]    acc_q, acc_n;
	logic                   ovf_q, ovf_n;
	logic                   szs_q, szs_n;
	logic [KW_COUNT-1:0]    cand_q, cand_n;
	logic [3:0]             idlen_q, idlen_n;

	logic [OFFSET_BITS-1:0] off_inc;
	logic [LINE_BITS-1:0]   line_inc;
	logic [COLUMN_BITS-1:0] col_inc;
	logic                   is_dig, is_alpha, is_hex;
	logic [3:0]             hex_d;
	logic [NUM_BITS+3:0]    dec_next, hex_next;
	logic [KW_COUNT-1:0]    cand_first, cand_keep;
	logic [KIND_BITS-1:0]   ident_kind;

	logic [KIND_BITS-1:0]   p_kind, i_kind;
	logic [ERR_BITS-1:0]    p_err, i_err;
	logic [NUM_BITS-1:0]    p_val;
	logic                   has_pend;
	logic [TOK_W-1:0]       p_vec, i_vec, s_vec, e_vec, r0, r1;
	logic                   flush, do_idle, i_emit;

	assign off_inc  = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
	assign col_inc  = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

	assign is_dig   = (char_byte >= "0") && (char_byte <= "9");
	assign is_alpha = ((char_byte >= "a") && (char_byte <= "z"))
		|| ((char_byte >= "A") && (char_byte <= "Z")) || (char_byte == "_");

	always_comb begin
		is_hex = 1'b1;
		hex_d  = char_byte[3:0];
		if (is_dig) begin
			hex_d = char_byte[3:0];
		end else if ((char_byte >= "a" && char_byte <= "f")
			|| (char_byte >= "A" && char_byte <= "F")) begin
			hex_d = char_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	// acc*10 + d and acc*16 + d, overflow if anything lands above bit 30
	assign dec_next = (NUM_BITS+4)'({acc_q, 3'b000}) + (NUM_BITS+4)'({acc_q, 1'b0})
		+ (NUM_BITS+4)'(char_byte[3:0]);
	assign hex_next = {acc_q, 4'b0000} | (NUM_BITS+4)'(hex_d);

	always_comb begin
		ident_kind = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			cand_first[k] = (kw_char(3'(k), 3'd0) == char_byte);
			cand_keep[k]  = cand_q[k] && (idlen_q < {1'b0, KW_LEN[k]})
				&& (kw_char(3'(k), idlen_q[2:0]) == char_byte);
			if (cand_q[k] && (idlen_q == {1'b0, KW_LEN[k]}))
				ident_kind = KIND_BITS'(int'(TK_HEADER) + k);
		end
	end

	// token still open when a terminator or end of text arrives
	always_comb begin
		has_pend = 1'b1;
		p_kind   = TK_STRING;
		p_err    = ERR_NONE;
		p_val    = '0;
		unique case (mode_q)
			M_DEC, M_HEX: begin
				if (ovf_q) begin
					p_kind = TK_ERROR;
					p_err  = ERR_TOO_LARGE;
				end else begin
					p_kind = TK_NUMBER;
					p_val  = acc_q;
				end
			end
			M_IDENT:  p_kind = ident_kind;
			M_STRING: p_kind = TK_STRING;
			default:  has_pend = 1'b0;
		endcase
	end

	// one-byte tokens started from idle
	always_comb begin
		i_err = ERR_NONE;
		unique case (char_byte)
			CH_LPAR: i_kind = TK_LPAREN;
			CH_RPAR: i_kind = TK_RPAREN;
			CH_LBR:  i_kind = TK_LBRACE;
			CH_RBR:  i_kind = TK_RBRACE;
			CH_SEMI: i_kind = TK_SEMI;
			CH_COL:  i_kind = TK_COLON;
			CH_EQ:   i_kind = TK_EQUALS;
			CH_CMA:  i_kind = TK_COMMA;
			default: begin
				i_kind = TK_ERROR;
				i_err  = ERR_UNEXPECTED;
			end
		endcase
	end

	assign p_vec = {p_kind, p_err, tso_q, OFFSET_BITS'(off_q - tso_q), line_q, col_q, p_val};
	assign i_vec = {i_kind, i_err, off_q, OFFSET_BITS'(off_inc - off_q), line_q, col_inc,
		NUM_BITS'(0)};
	assign s_vec = {TK_STRING, ERR_NONE, tso_q, OFFSET_BITS'(off_inc - tso_q), line_q, col_inc,
		NUM_BITS'(0)};
	assign e_vec = {TK_EOF, ERR_NONE, off_q, OFFSET_BITS'(0), line_q, col_inc, NUM_BITS'(0)};

	always_comb begin
		mode_n  = mode_q;
		qk_n    = qk_q;
		tso_n   = tso_q;
		off_n   = off_q;
		line_n  = line_q;
		col_n   = col_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		szs_n   = szs_q;
		cand_n  = cand_q;
		idlen_n = idlen_q;
		flush   = 1'b0;
		do_idle = 1'b0;
		i_emit  = 1'b0;
		push    = '0;
		r0      = p_vec;
		r1      = i_vec;

		if (end_of_text) begin
			push.first  = 1'b1;
			push.second = has_pend;
			r0          = has_pend ? p_vec : e_vec;
			r1          = e_vec;
			mode_n      = M_IDLE;
			qk_n        = 1'b0;
			tso_n       = '0;
			off_n       = '0;
			line_n      = LINE_BITS'(1);
			col_n       = COLUMN_BITS'(1);
			acc_n       = '0;
			ovf_n       = 1'b0;
			szs_n       = 1'b0;
			cand_n      = '0;
			idlen_n     = '0;
		end else begin
			unique case (mode_q)
				M_COMMENT: begin
					if (char_byte == CH_LF) begin
						do_idle = 1'b1;
					end else begin
						off_n = off_inc;
						col_n = col_inc;
					end
				end
				M_DEC: begin
					szs_n = 1'b0;
					if (is_dig) begin
						acc_n = dec_next[NUM_BITS-1:0];
						ovf_n = ovf_q | (|dec_next[NUM_BITS+3:NUM_BITS]);
						off_n = off_inc;
						col_n = col_inc;
					end else if (char_byte == CH_X && szs_q) begin
						mode_n = M_HEX;
						acc_n  = '0;
						ovf_n  = 1'b0;
						off_n  = off_inc;
						col_n  = col_inc;
					end else begin
						flush   = 1'b1;
						do_idle = 1'b1;
					end
				end
				M_HEX: begin
					if (is_hex) begin
						acc_n = hex_next[NUM_BITS-1:0];
						ovf_n = ovf_q | (|hex_next[NUM_BITS+3:NUM_BITS]);
						off_n = off_inc;
						col_n = col_inc;
					end else begin
						flush   = 1'b1;
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha) begin
						cand_n  = cand_keep;
						idlen_n = (idlen_q == 4'd15) ? idlen_q : idlen_q + 4'd1;
						off_n   = off_inc;
						col_n   = col_inc;
					end else begin
						flush   = 1'b1;
						do_idle = 1'b1;
					end
				end
				M_STRING: begin
					off_n = off_inc;
					col_n = col_inc;
					if (char_byte == (qk_q ? CH_SQ : CH_DQ)) begin
						push.first = 1'b1;
						r0         = s_vec;
						mode_n     = M_IDLE;
					end
				end
				default: do_idle = 1'b1;
			endcase

			if (do_idle) begin
				mode_n = M_IDLE;
				off_n  = off_inc;
				col_n  = col_inc;
				priority if (char_byte == CH_SP || char_byte == CH_TAB || char_byte == CH_CR) begin
					// whitespace: just advance
				end else if (char_byte == CH_LF) begin
					line_n = line_inc;
					col_n  = COLUMN_BITS'(1);
				end else if (char_byte == CH_HASH) begin
					mode_n = M_COMMENT;
				end else if (is_dig) begin
					tso_n  = off_q;
					mode_n = M_DEC;
					acc_n  = NUM_BITS'(char_byte[3:0]);
					ovf_n  = 1'b0;
					szs_n  = (char_byte == "0");
				end else if (is_alpha) begin
					tso_n   = off_q;
					mode_n  = M_IDENT;
					cand_n  = cand_first;
					idlen_n = 4'd1;
				end else if (char_byte == CH_DQ || char_byte == CH_SQ) begin
					tso_n  = off_q;
					mode_n = M_STRING;
					qk_n   = (char_byte == CH_SQ);
				end else begin
					tso_n  = off_q;
					i_emit = 1'b1;
				end

				if (flush) begin
					push.first  = 1'b1;
					push.second = i_emit;
					r0          = p_vec;
					r1          = i_vec;
				end else if (i_emit) begin
					push.first = 1'b1;
					r0         = i_vec;
				end
			end
		end

		if (!take) push = '0;
	end

	assign res0 = {r0, !push.second};
	assign res1 = {r1, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			qk_q    <= 1'b0;
			tso_q   <= '0;
			off_q   <= '0;
			line_q  <= LINE_BITS'(1);
			col_q   <= COLUMN_BITS'(1);
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			szs_q   <= 1'b0;
			cand_q  <= '0;
			idlen_q <= '0;
		end else if (take) begin
			mode_q  <= mode_n;
			qk_q    <= qk_n;
			tso_q   <= tso_n;
			off_q   <= off_n;
			line_q  <= line_n;
			col_q   <= col_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			szs_q   <= szs_n;
			cand_q  <= cand_n;
			idlen_q <= idlen_n;
		end
	end

endmodule

// File: design/mctok_outq.sv
// ----------------------------------------------------------------------------
// mctok_outq
// Four-entry token queue: takes one or two tokens per cycle from the scanner
// while it has room for two, hands one per cycle to a ready output channel.
// ----------------------------------------------------------------------------
module mctok_outq #(
	parameter int W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mctok_pkg::mctok_push_t push,
	input  logic [W-1:0]           wdata0,
	input  logic [W-1:0]           wdata1,
	output logic                   space2,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [W-1:0]           out_data
);
	import mctok_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	logic [AW:0]   n_push;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	// worst case push is two entries; ignore this cycle's pop to keep ready registered-only
	assign space2    = (cnt_q <= (AW+1)'(DEPTH - 2));
	assign n_push    = (AW+1)'(push.first) + (AW+1)'(push.second);

	always_ff @(posedge clk) begin
		if (push.first)  mem_q[wp_q] <= wdata0;
		if (push.second) mem_q[wp_q + AW'(1)] <= wdata1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[AW-1:0];
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + n_push - (AW+1)'(pop);
		end
	end

endmodule

// File: design/mctok_chk.sv
// ----------------------------------------------------------------------------
// mctok_chk
// Port-level checks of the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
module mctok_chk #(
	parameter int OFFSET_BITS = mctok_pkg::OFFSET_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [mctok_pkg::KIND_BITS-1:0] token_kind,
	input logic [mctok_pkg::ERR_BITS-1:0]  error_code,
	input logic [OFFSET_BITS-1:0]          token_length,
	input logic [mctok_pkg::NUM_BITS-1:0]  number_value,
	input logic                            last_of_run
);
	import mctok_pkg::*;

	// stalled transfer keeps its token
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_length)
			&& $stable(number_value) && $stable(last_of_run))
		else $error("token changed while stalled");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == TK_EOF |-> last_of_run && token_length == '0
			&& number_value == '0)
		else $error("malformed EOF token");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((token_kind == TK_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match token kind");

	a_num_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != TK_NUMBER |-> number_value == '0)
		else $error("value on non-number token");

endmodule

bind microcode_source_tokenizer_top mctok_chk #(
	.OFFSET_BITS(OFFSET_BITS)
) u_mctok_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.token_kind  (tokens.token_kind),
	.error_code  (tokens.error_code),
	.token_length(tokens.token_length),
	.number_value(tokens.number_value),
	.last_of_run (tokens.last_of_run)
);
